/* design/utf8_to_gbk_converter_top_defines.svh */
// assertion macros used by the utf8 to gbk converter checker
`ifndef UTF8_TO_GBK_CONVERTER_TOP_DEFINES_SVH
`define UTF8_TO_GBK_CONVERTER_TOP_DEFINES_SVH

// concurrent check on clk, off while rst is high
`define UTG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// concurrent check on clk that also holds during reset
`define UTG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/utg_pkg.sv */
// shared types and constants of the utf8 to gbk converter
package utg_pkg;

  localparam int TABLE_DEPTH_DEF = 8192;

  localparam int ENTRY_COUNT_W = 14;
  localparam int LIMIT_W       = 16;
  localparam int INDEX_W       = 13;
  localparam int CODE_W        = 16;
  localparam int BYTE_W        = 8;
  localparam int KIND_W        = 2;
  localparam int ENTRY_W       = 2 * CODE_W;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 16'hFFFF;

  // register index, taken from paddr bit 2
  localparam logic REG_ENTRY_COUNT  = 1'b0;
  localparam logic REG_OUTPUT_LIMIT = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ILSEQ = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd3;

  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_E0     = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_F0     = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE   = 8'h80;
  localparam logic [BYTE_W-1:0] SUBST_BYTE  = 8'h3F;

  typedef struct packed {
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic [LIMIT_W-1:0]       output_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_ILSEQ,
    ST_EMIT,
    ST_FINISH
  } state_t;

endpackage

/* design/utg_ram.sv */
// generic simple dual-port ram with registered read
module utg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/utg_regs.sv */
// apb configuration registers of the converter
module utg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [utg_pkg::PADDR_W-1:0]   paddr,
  input  logic [utg_pkg::PDATA_W-1:0]   pwdata,
  output logic [utg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output utg_pkg::cfg_t                 cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_count  <= '0;
      cfg.output_limit <= utg_pkg::OUTPUT_LIMIT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        utg_pkg::REG_ENTRY_COUNT: begin
          cfg.entry_count <= pwdata[utg_pkg::ENTRY_COUNT_W-1:0];
        end
        utg_pkg::REG_OUTPUT_LIMIT: begin
          cfg.output_limit <= pwdata[utg_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      utg_pkg::REG_ENTRY_COUNT:  prdata = utg_pkg::PDATA_W'(cfg.entry_count);
      utg_pkg::REG_OUTPUT_LIMIT: prdata = utg_pkg::PDATA_W'(cfg.output_limit);
      default:                   prdata = '0;
    endcase
  end

endmodule

/* design/utg_engine.sv */
// sequencer: utf8 window decode, table binary search and result emission
module utg_engine #(
  parameter int TABLE_DEPTH = utg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  utg_pkg::cfg_t                      cfg,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [utg_pkg::INDEX_W-1:0]        entry_index,
  input  logic [utg_pkg::CODE_W-1:0]         entry_code_point,
  input  logic [utg_pkg::CODE_W-1:0]         entry_gbk_code,
  input  logic [utg_pkg::BYTE_W-1:0]         data_byte,
  input  logic                               end_of_string,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [utg_pkg::BYTE_W-1:0]         out_byte,
  output logic [utg_pkg::KIND_W-1:0]         result_kind,
  output logic                               last_of_run,
  output logic [utg_pkg::LIMIT_W-1:0]        bytes_written,
  output logic                               ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]     ram_waddr,
  output logic [utg_pkg::ENTRY_W-1:0]        ram_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0]     ram_raddr,
  input  logic [utg_pkg::ENTRY_W-1:0]        ram_rdata
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  utg_pkg::state_t state, state_next;

  logic [7:0]         byte_q;
  logic               eos_q;
  logic [7:0]         w0, w0_next;
  logic [7:0]         w1, w1_next;
  logic [1:0]         fill, fill_next;
  logic [15:0]        out_count, out_count_next;
  logic               err, err_next;
  logic [15:0]        cp_q, cp_next;
  logic [CNT_W-1:0]   lo, lo_next;
  logic [CNT_W-1:0]   hx, hx_next;
  logic [ADDR_W-1:0]  mid, mid_next;
  logic [7:0]         eb0, eb0_next;
  logic [7:0]         eb1, eb1_next;
  logic               ecnt, ecnt_next;
  logic               eidx, eidx_next;

  logic               res_load;
  logic [7:0]         res_byte;
  logic [1:0]         res_kind;
  logic               res_last;
  logic [15:0]        res_count;

  logic               accept;
  logic               slot_free;
  logic [31:0]        idx_ext;
  logic [31:0]        cnt_ext;
  logic [CNT_W-1:0]   cnt_eff;

  // decode of the window with the new byte
  logic [7:0]         lead, b1, b2;
  logic [1:0]         need;
  logic [1:0]         fill_new;
  logic               complete;
  logic               cont_bad;
  logic               bad;
  logic [15:0]        cp_dec;
  logic               is_ascii;

  // search step
  logic [15:0]        key;
  logic               hit;
  logic [CNT_W-1:0]   mid_ext;
  logic [CNT_W-1:0]   lo_step, hx_step;
  logic               more;
  logic [CNT_W-1:0]   lo_in, hx_in;
  logic [CNT_W:0]     mid_sum;

  logic               full;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != utg_pkg::ST_IDLE);

  // table loads go straight to the memory from the input port
  assign idx_ext   = 32'(entry_index);
  assign ram_we    = accept && (cmd == utg_pkg::CMD_LOAD) && (idx_ext < 32'(TABLE_DEPTH));
  assign ram_waddr = idx_ext[ADDR_W-1:0];
  assign ram_wdata = {entry_code_point, entry_gbk_code};

  assign cnt_ext = 32'(cfg.entry_count);
  assign cnt_eff = (cnt_ext > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cnt_ext);

  always_comb begin
    lead     = (fill == 2'd0) ? byte_q : w0;
    b1       = (fill == 2'd1) ? byte_q : w1;
    b2       = byte_q;
    fill_new = fill + 2'd1;
    if (lead < utg_pkg::ASCII_LIMIT) begin
      need = 2'd1;
    end else if ((lead & utg_pkg::MASK_E0) == utg_pkg::LEAD2_CODE) begin
      need = 2'd2;
    end else if ((lead & utg_pkg::MASK_F0) == utg_pkg::LEAD3_CODE) begin
      need = 2'd3;
    end else begin
      need = 2'd0;
    end
    complete = (need != 2'd0) && (fill_new >= need);
    case (need)
      2'd2:    cont_bad = (b1 & utg_pkg::CONT_MASK) != utg_pkg::CONT_CODE;
      2'd3:    cont_bad = ((b1 & utg_pkg::CONT_MASK) != utg_pkg::CONT_CODE) ||
                          ((b2 & utg_pkg::CONT_MASK) != utg_pkg::CONT_CODE);
      default: cont_bad = 1'b0;
    endcase
    bad = (need == 2'd0) || (complete && cont_bad);
    case (need)
      2'd2:    cp_dec = {5'd0, lead[4:0], b1[5:0]};
      2'd3:    cp_dec = {lead[3:0], b1[5:0], b2[5:0]};
      default: cp_dec = {8'd0, lead};
    endcase
    is_ascii = cp_dec < 16'(utg_pkg::ASCII_LIMIT);
  end

  // one probe of the binary search; hx is one past the upper bound
  always_comb begin
    key     = ram_rdata[31:16];
    hit     = (key == cp_q);
    mid_ext = CNT_W'(mid);
    if (key < cp_q) begin
      lo_step = mid_ext + 1'b1;
      hx_step = hx;
    end else begin
      lo_step = lo;
      hx_step = mid_ext;
    end
    more = lo_step < hx_step;
    if (state == utg_pkg::ST_SEARCH) begin
      lo_in = lo_step;
      hx_in = hx_step;
    end else begin
      lo_in = '0;
      hx_in = cnt_eff;
    end
    mid_sum   = {1'b0, lo_in} + {1'b0, hx_in} - 1'b1;
    ram_raddr = mid_sum[ADDR_W:1];
  end

  assign full = out_count >= cfg.output_limit;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      utg_pkg::ST_IDLE: begin
        if (accept && (cmd == utg_pkg::CMD_DATA)) begin
          state_next = utg_pkg::ST_DECODE;
        end
      end
      utg_pkg::ST_DECODE: begin
        if (err) begin
          state_next = utg_pkg::ST_FINISH;
        end else if (bad) begin
          state_next = utg_pkg::ST_ILSEQ;
        end else if (!complete) begin
          state_next = utg_pkg::ST_FINISH;
        end else if (is_ascii || (cnt_eff == '0)) begin
          state_next = utg_pkg::ST_EMIT;
        end else begin
          state_next = utg_pkg::ST_SEARCH;
        end
      end
      utg_pkg::ST_SEARCH: begin
        if (hit || !more) begin
          state_next = utg_pkg::ST_EMIT;
        end
      end
      utg_pkg::ST_ILSEQ: begin
        if (slot_free) begin
          state_next = utg_pkg::ST_FINISH;
        end
      end
      utg_pkg::ST_EMIT: begin
        if (slot_free && (full || (eidx == ecnt))) begin
          state_next = utg_pkg::ST_FINISH;
        end
      end
      utg_pkg::ST_FINISH: begin
        if (!eos_q || err || slot_free) begin
          state_next = utg_pkg::ST_IDLE;
        end
      end
      default: state_next = utg_pkg::ST_IDLE;
    endcase
  end

  // datapath and result selection
  always_comb begin
    w0_next        = w0;
    w1_next        = w1;
    fill_next      = fill;
    out_count_next = out_count;
    err_next       = err;
    cp_next        = cp_q;
    lo_next        = lo;
    hx_next        = hx;
    mid_next       = mid;
    eb0_next       = eb0;
    eb1_next       = eb1;
    ecnt_next      = ecnt;
    eidx_next      = eidx;
    res_load       = 1'b0;
    res_byte       = '0;
    res_kind       = utg_pkg::KIND_DATA;
    res_last       = 1'b1;
    res_count      = out_count;
    case (state)
      utg_pkg::ST_DECODE: begin
        if (!err) begin
          if (bad || complete) begin
            fill_next = '0;
          end else begin
            fill_next = fill_new;
            if (fill == 2'd0) begin
              w0_next = byte_q;
            end else begin
              w1_next = byte_q;
            end
          end
          cp_next   = cp_dec;
          lo_next   = lo_in;
          hx_next   = hx_in;
          mid_next  = ram_raddr;
          eidx_next = 1'b0;
          ecnt_next = 1'b0;
          eb0_next  = is_ascii ? cp_dec[7:0] : utg_pkg::SUBST_BYTE;
        end
      end
      utg_pkg::ST_SEARCH: begin
        lo_next  = lo_step;
        hx_next  = hx_step;
        mid_next = ram_raddr;
        if (hit) begin
          eb0_next  = ram_rdata[15:8];
          eb1_next  = ram_rdata[7:0];
          ecnt_next = 1'b1;
        end else begin
          eb0_next  = utg_pkg::SUBST_BYTE;
          ecnt_next = 1'b0;
        end
      end
      utg_pkg::ST_ILSEQ: begin
        if (slot_free) begin
          res_load = 1'b1;
          res_kind = utg_pkg::KIND_ILSEQ;
          err_next = 1'b1;
        end
      end
      utg_pkg::ST_EMIT: begin
        if (slot_free) begin
          res_load = 1'b1;
          if (full) begin
            // overflow cuts the rest of this character
            res_kind = utg_pkg::KIND_FULL;
            err_next = 1'b1;
          end else begin
            out_count_next = out_count + 16'd1;
            res_count      = out_count + 16'd1;
            res_byte       = eidx ? eb1 : eb0;
            res_last       = (eidx == ecnt) && !eos_q;
            eidx_next      = 1'b1;
          end
        end
      end
      utg_pkg::ST_FINISH: begin
        if (eos_q) begin
          if (!err) begin
            res_load = slot_free;
            res_kind = utg_pkg::KIND_DONE;
          end
          if (err || slot_free) begin
            w0_next        = '0;
            w1_next        = '0;
            fill_next      = '0;
            out_count_next = '0;
            err_next       = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= utg_pkg::ST_IDLE;
      w0        <= '0;
      w1        <= '0;
      fill      <= '0;
      out_count <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      w0        <= w0_next;
      w1        <= w1_next;
      fill      <= fill_next;
      out_count <= out_count_next;
      err       <= err_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= data_byte;
      eos_q  <= end_of_string;
    end
    cp_q <= cp_next;
    lo   <= lo_next;
    hx   <= hx_next;
    mid  <= mid_next;
    eb0  <= eb0_next;
    eb1  <= eb1_next;
    ecnt <= ecnt_next;
    eidx <= eidx_next;
    if (res_load) begin
      out_byte      <= res_byte;
      result_kind   <= res_kind;
      last_of_run   <= res_last;
      bytes_written <= res_count;
    end
  end

endmodule

/* design/utf8_to_gbk_converter_top.sv */
// UTF-8 to GBK converter: one item at a time. A load transaction writes one table entry into
// the table memory. A data byte passes a decode state, then for a complete multi-byte character
// that is not ASCII a binary search of the table memory, one probe per search step (at most
// clog2(entry_count)+1 probes, so 14 for 8192 entries), then one emit step per output result
// (one or two bytes, or a status) and a finish state, which also emits the done status at end
// of string unless an error status came first. The search loop around the single read port of
// the table memory sets the pace; a stalled output holds the result. The table memory has no
// reset: entries must be loaded before they are searched.
module utf8_to_gbk_converter_top #(
  parameter int TABLE_DEPTH = utg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [utg_pkg::PADDR_W-1:0]   paddr,
  input  logic [utg_pkg::PDATA_W-1:0]   pwdata,
  output logic [utg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [utg_pkg::INDEX_W-1:0]   entry_index,
  input  logic [utg_pkg::CODE_W-1:0]    entry_code_point,
  input  logic [utg_pkg::CODE_W-1:0]    entry_gbk_code,
  input  logic [utg_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          end_of_string,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utg_pkg::BYTE_W-1:0]    out_byte,
  output logic [utg_pkg::KIND_W-1:0]    result_kind,
  output logic                          last_of_run,
  output logic [utg_pkg::LIMIT_W-1:0]   bytes_written
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  utg_pkg::cfg_t                cfg;
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [utg_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [utg_pkg::ENTRY_W-1:0]  ram_rdata;

  utg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  utg_ram #(
    .WIDTH (utg_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  utg_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .entry_index      (entry_index),
    .entry_code_point (entry_code_point),
    .entry_gbk_code   (entry_gbk_code),
    .data_byte        (data_byte),
    .end_of_string    (end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .result_kind      (result_kind),
    .last_of_run      (last_of_run),
    .bytes_written    (bytes_written),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

endmodule

/* design/utg_chk.sv */
// port-level checker of the converter, bound to the top level
`include "utf8_to_gbk_converter_top_defines.svh"

module utg_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          cmd,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [utg_pkg::BYTE_W-1:0]    out_byte,
  input logic [utg_pkg::KIND_W-1:0]    result_kind,
  input logic                          last_of_run,
  input logic [utg_pkg::LIMIT_W-1:0]   bytes_written
);

  // a stalled result transaction holds
  `UTG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(result_kind) && $stable(bytes_written), "stalled result changed")

  // status results carry no byte and always close the run
  `UTG_ASSERT(a_status_last, out_valid && (result_kind == utg_pkg::KIND_DONE || result_kind == utg_pkg::KIND_ILSEQ || result_kind == utg_pkg::KIND_FULL) |-> last_of_run && (out_byte == '0), "status result malformed")

  // a data byte is always counted
  `UTG_ASSERT(a_data_count, out_valid && (result_kind == utg_pkg::KIND_DATA) |-> bytes_written != '0, "data byte with zero count")

  // a data transaction keeps the input stalled while it is worked on
  `UTG_ASSERT(a_busy_after_data, in_valid && !in_stall && (cmd == utg_pkg::CMD_DATA) |=> in_stall, "input not stalled after data byte")

endmodule

bind utf8_to_gbk_converter_top utg_chk u_chk (.*);
